FILE: src/hcnt_pkg.sv
// Shared constants, types and hash helpers for the hash-consed node table.
package hcnt_pkg;

  localparam int unsigned Log2Slots  = 12;
  localparam int unsigned SlotCount  = 1 << Log2Slots;
  localparam int unsigned SlotW      = Log2Slots;
  localparam int unsigned HandleW    = 13;
  localparam int unsigned WordsPerNode = 8;
  localparam int unsigned WordAddrW  = SlotW + 3;
  localparam int unsigned CountW     = 16;
  localparam int unsigned TagW       = 8;

  localparam logic [31:0] FnvPrime = 32'h0100_0193;
  localparam logic [31:0] FnvSeed  = 32'h811C_9DC5;
  localparam logic [12:0] FullLimitReset = 13'd3840;

  // Operation codes.
  localparam logic [1:0] KindInsert = 2'd0;
  localparam logic [1:0] KindRemove = 2'd1;
  localparam logic [1:0] KindRead   = 2'd2;
  localparam logic [1:0] KindClear  = 2'd3;

  // Result status codes.
  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StMatched  = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StDropped  = 3'd3;
  localparam logic [2:0] StFreed    = 3'd4;
  localparam logic [2:0] StBadHandle = 3'd5;
  localparam logic [2:0] StReadDone = 3'd6;
  localparam logic [2:0] StCleared  = 3'd7;

  typedef logic [31:0] word_t;
  typedef word_t [WordsPerNode-1:0] node_t;

  // One FNV-1a step over a single byte.
  function automatic word_t fnv_byte(input word_t h, input logic [7:0] b);
    word_t x;
    x = h ^ {24'd0, b};
    return x * FnvPrime;
  endfunction

endpackage

FILE: src/hcnt_ram.sv
// Generic single-port RAM with registered read.
module hcnt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: src/hash_consed_node_table_unit.sv
// Top level of the hash-consed node table: sequencer, FNV-1a unit and slot memories.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-----------------------------
//  command  | start_i, kind_i, child_*_i, handle_i      | taken when start_i & !busy_o
//  result   | done_o, status_o, result_handle_o, ...    | one-cycle strobe on done_o
//  config   | full_limit_we_i, full_limit_i             | written when full_limit_we_i
//
// busy_o is high from the accepting edge; done_o follows in the first cycle with busy_o
// low. Insert: hashing (one byte per cycle through the multiplier), a setup step, a tag
// read and check per probed slot, a compare of the stored words on a tag hit, then a
// count bump or a write of the new node. Remove reads the count and, for a live slot,
// updates it; read fetches the node words; refusals and bad handles skip to the result;
// clear and the reset pass zero the tags with busy_o high. Results cannot be stalled.
module hash_consed_node_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] child_0_i,
  input  logic [31:0] child_1_i,
  input  logic [31:0] child_2_i,
  input  logic [31:0] child_3_i,
  input  logic [31:0] child_4_i,
  input  logic [31:0] child_5_i,
  input  logic [31:0] child_6_i,
  input  logic [31:0] child_7_i,
  input  logic [12:0] handle_i,
  input  logic        full_limit_we_i,
  input  logic [12:0] full_limit_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [12:0] result_handle_o,
  output logic [31:0] out_child_0_o,
  output logic [31:0] out_child_1_o,
  output logic [31:0] out_child_2_o,
  output logic [31:0] out_child_3_o,
  output logic [31:0] out_child_4_o,
  output logic [31:0] out_child_5_o,
  output logic [31:0] out_child_6_o,
  output logic [31:0] out_child_7_o,
  output logic [12:0] fill_level_o
);
  localparam int unsigned SW = hcnt_pkg::SlotW;

  localparam logic [3:0] SClr     = 4'd0;
  localparam logic [3:0] SIdle    = 4'd1;
  localparam logic [3:0] SHash    = 4'd2;
  localparam logic [3:0] STagRd   = 4'd3;
  localparam logic [3:0] STagChk  = 4'd4;
  localparam logic [3:0] SCmpRd   = 4'd5;
  localparam logic [3:0] SWrNode  = 4'd6;
  localparam logic [3:0] SCntRd   = 4'd7;
  localparam logic [3:0] SCntChk  = 4'd8;
  localparam logic [3:0] SRdWords = 4'd9;
  localparam logic [3:0] SDone    = 4'd10;

  logic [3:0]  state_q, state_d;
  logic [12:0] limit_q;
  logic [12:0] occ_q, occ_d;
  logic [1:0]  kind_q;
  hcnt_pkg::node_t node_q, node_d, rnode_q, rnode_d;
  logic [31:0] hash_q, hash_d;
  logic [4:0]  byte_q, byte_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [SW:0] probes_q, probes_d;
  logic [3:0]  wcnt_q, wcnt_d;
  logic        match_q, match_d;
  logic [7:0]  tag_q, tag_d;
  logic [2:0]  st_q, st_d;
  logic [12:0] rh_q, rh_d;
  logic        done_q, done_d;
  logic [SW-1:0] clr_q, clr_d;
  logic        seen_q, seen_d;

  // Memory ports.
  logic          tag_we, cnt_we, word_we;
  logic [SW-1:0] tag_addr, cnt_addr;
  logic [hcnt_pkg::WordAddrW-1:0] word_addr;
  logic [7:0]    tag_wd, tag_rd;
  logic [15:0]   cnt_wd, cnt_rd;
  logic [31:0]   word_wd, word_rd;

  hcnt_ram #(.Width(8), .Depth(hcnt_pkg::SlotCount)) u_tags (
    .clk_i, .we_i(tag_we), .addr_i(tag_addr), .wdata_i(tag_wd), .rdata_o(tag_rd));
  hcnt_ram #(.Width(16), .Depth(hcnt_pkg::SlotCount)) u_counts (
    .clk_i, .we_i(cnt_we), .addr_i(cnt_addr), .wdata_i(cnt_wd), .rdata_o(cnt_rd));
  hcnt_ram #(.Width(32), .Depth(hcnt_pkg::SlotCount * hcnt_pkg::WordsPerNode)) u_words (
    .clk_i, .we_i(word_we), .addr_i(word_addr), .wdata_i(word_wd), .rdata_o(word_rd));

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= hcnt_pkg::FullLimitReset;
    end else if (full_limit_we_i) begin
      limit_q <= full_limit_i;
    end
  end

  logic [7:0]  cur_byte;
  logic [31:0] cur_word;
  assign cur_word = node_q[byte_q[4:2]];
  assign cur_byte = cur_word[{byte_q[1:0], 3'b000} +: 8];
  assign busy_o   = (state_q != SIdle);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    occ_d    = occ_q;
    node_d   = node_q;
    rnode_d  = rnode_q;
    hash_d   = hash_q;
    byte_d   = byte_q;
    slot_d   = slot_q;
    probes_d = probes_q;
    wcnt_d   = wcnt_q;
    match_d  = match_q;
    tag_d    = tag_q;
    st_d     = st_q;
    rh_d     = rh_q;
    done_d   = 1'b0;
    clr_d    = clr_q;
    seen_d   = seen_q;
    tag_we = 1'b0; tag_addr = slot_q; tag_wd = 8'd0;
    cnt_we = 1'b0; cnt_addr = slot_q; cnt_wd = 16'd0;
    word_we = 1'b0; word_addr = {slot_q, wcnt_q[2:0]}; word_wd = node_q[wcnt_q[2:0]];
    unique case (state_q)
      SClr: begin
        tag_we = 1'b1; tag_addr = clr_q;
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = seen_q ? SDone : SIdle;
          done_d  = seen_q;
        end
      end
      SIdle: begin
        if (start_i) begin
          node_d = {child_7_i, child_6_i, child_5_i, child_4_i,
                    child_3_i, child_2_i, child_1_i, child_0_i};
          rnode_d = '0;
          rh_d    = '0;
          st_d    = hcnt_pkg::StBadHandle;
          seen_d  = 1'b0;
          unique case (kind_i)
            hcnt_pkg::KindInsert: begin
              if (occ_q > limit_q) begin
                st_d = hcnt_pkg::StFull; state_d = SDone;
              end else begin
                hash_d = hcnt_pkg::FnvSeed; byte_d = '0; state_d = SHash;
              end
            end
            hcnt_pkg::KindRemove, hcnt_pkg::KindRead: begin
              if (handle_i == '0 || handle_i > 13'(hcnt_pkg::SlotCount)) begin
                state_d = SDone;
              end else begin
                slot_d  = 12'(handle_i - 1'b1);
                wcnt_d  = '0;
                state_d = (kind_i == hcnt_pkg::KindRead) ? SRdWords : SCntRd;
              end
            end
            default: begin
              occ_d = '0; st_d = hcnt_pkg::StCleared; clr_d = '0;
              seen_d = 1'b1; state_d = SClr;
            end
          endcase
        end
      end
      SHash: begin
        hash_d = hcnt_pkg::fnv_byte(hash_q, cur_byte);
        // The byte counter stays on the last byte to mark the setup cycle.
        if (&byte_q) begin
          state_d = STagRd;
        end else begin
          byte_d = byte_q + 1'b1;
        end
      end
      STagRd: begin
        if (byte_q == '1) begin
          // First entry after hashing: derive start slot and tag.
          slot_d   = hash_q[SW-1:0] & ~12'hF;
          tag_d    = hash_q[SW +: 8] | 8'd1;
          probes_d = '0;
          byte_d   = '0;
        end else begin
          state_d = STagChk;
        end
      end
      STagChk: begin
        if (tag_rd == 8'd0) begin
          wcnt_d = '0; state_d = SWrNode;
        end else if (tag_rd == tag_q) begin
          wcnt_d = '0; match_d = 1'b1; state_d = SCmpRd;
        end else begin
          slot_d = slot_q + 1'b1;
          probes_d = probes_q + 1'b1;
          state_d = (probes_q == 13'(hcnt_pkg::SlotCount - 1)) ? SDone : STagRd;
          st_d = hcnt_pkg::StFull;
        end
      end
      SCmpRd: begin
        // wcnt 0..7 issues reads; the registered data arrives in the next cycle.
        if (wcnt_q != '0 && word_rd != node_q[3'(wcnt_q - 1'b1)]) begin
          match_d = 1'b0;
        end
        if (wcnt_q == 4'd8) begin
          if (match_d) begin
            state_d = SCntRd;
          end else begin
            slot_d = slot_q + 1'b1;
            probes_d = probes_q + 1'b1;
            state_d = (probes_q == 13'(hcnt_pkg::SlotCount - 1)) ? SDone : STagRd;
            st_d = hcnt_pkg::StFull;
          end
        end else begin
          wcnt_d = wcnt_q + 1'b1;
        end
      end
      SWrNode: begin
        word_we = 1'b1;
        wcnt_d = wcnt_q + 1'b1;
        if (wcnt_q == 4'd7) begin
          tag_we = 1'b1; tag_wd = tag_q;
          cnt_we = 1'b1; cnt_wd = 16'd1;
          occ_d = occ_q + 1'b1;
          st_d = hcnt_pkg::StInserted;
          rh_d = {1'b0, slot_q} + 13'd1;
          state_d = SDone;
        end
      end
      SCntRd: begin
        state_d = SCntChk;
      end
      SCntChk: begin
        if (kind_q == hcnt_pkg::KindInsert) begin
          cnt_we = 1'b1;
          cnt_wd = (&cnt_rd) ? cnt_rd : cnt_rd + 1'b1;
          st_d = hcnt_pkg::StMatched;
          rh_d = {1'b0, slot_q} + 13'd1;
        end else if (tag_rd != 8'd0) begin
          cnt_we = 1'b1;
          cnt_wd = (cnt_rd != 16'd0) ? cnt_rd - 1'b1 : 16'd0;
          if (cnt_wd == 16'd0) begin
            tag_we = 1'b1;
            if (occ_q != '0) occ_d = occ_q - 1'b1;
            st_d = hcnt_pkg::StFreed;
          end else begin
            st_d = hcnt_pkg::StDropped;
          end
        end
        state_d = SDone;
      end
      SRdWords: begin
        if (wcnt_q != '0) begin
          rnode_d[3'(wcnt_q - 1'b1)] = word_rd;
        end
        wcnt_d = wcnt_q + 1'b1;
        if (wcnt_q == 4'd8) begin
          st_d = hcnt_pkg::StReadDone;
          state_d = SDone;
        end
      end
      SDone: begin
        done_d  = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
    if (state_q == SClr && seen_q) begin
      done_d = 1'b0;
    end
  end

  // Control and payload registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
      occ_q   <= '0;
      done_q  <= 1'b0;
      clr_q   <= '0;
      seen_q  <= 1'b0;
      byte_q  <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      done_q  <= done_d;
      clr_q   <= clr_d;
      seen_q  <= seen_d;
      byte_q  <= byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start_i) begin
      kind_q   <= kind_i;
    end
    node_q   <= node_d;
    rnode_q  <= rnode_d;
    hash_q   <= hash_d;
    slot_q   <= slot_d;
    probes_q <= probes_d;
    wcnt_q   <= wcnt_d;
    match_q  <= match_d;
    tag_q    <= tag_d;
    st_q     <= st_d;
    rh_q     <= rh_d;
  end

  assign done_o          = done_q;
  assign status_o        = st_q;
  assign result_handle_o = rh_q;
  assign out_child_0_o   = rnode_q[0];
  assign out_child_1_o   = rnode_q[1];
  assign out_child_2_o   = rnode_q[2];
  assign out_child_3_o   = rnode_q[3];
  assign out_child_4_o   = rnode_q[4];
  assign out_child_5_o   = rnode_q[5];
  assign out_child_6_o   = rnode_q[6];
  assign out_child_7_o   = rnode_q[7];
  assign fill_level_o    = occ_q;
endmodule

FILE: src/hcnt_checker.sv
// Port-level checker for the node table, bound to the top level.
module hcnt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [12:0] result_handle_o,
  input logic [12:0] fill_level_o
);
  // A result strobe ends the transaction, so it lasts one cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");

  // An accepted command makes the unit busy.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("not busy");

  // Only inserts return a handle.
  a_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != hcnt_pkg::StInserted && status_o != hcnt_pkg::StMatched)
    |-> result_handle_o == '0)
    else $error("stray handle");

  // A clear leaves the table empty.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == hcnt_pkg::StCleared) |-> fill_level_o == '0)
    else $error("fill after clear");
endmodule

bind hash_consed_node_table_unit hcnt_checker u_hcnt_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .status_o,
  .result_handle_o, .fill_level_o);

FILE: bench/tb_hash_consed_node_table_unit.sv
// Self-checking testbench for the hash-consed node table unit.
module tb_hash_consed_node_table_unit;

  localparam int unsigned CycleLimit = 20000000;
  localparam int unsigned PoolSize   = 24;

  // Expected outcome of one transaction.
  typedef struct {
    logic [2:0]  status;
    logic [12:0] hnd;
    hcnt_pkg::node_t words;
    logic [12:0] fill;
  } outcome_t;

  // One row of the directed plan.
  typedef struct {
    logic [1:0]  kind;
    int          pattern;
    bit          use_last;
    logic [12:0] hnd;
    bit          typed;
    logic [2:0]  status;
    logic [12:0] fill;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  kind_i = hcnt_pkg::KindInsert;
  logic [31:0] child_0_i = '0, child_1_i = '0, child_2_i = '0, child_3_i = '0;
  logic [31:0] child_4_i = '0, child_5_i = '0, child_6_i = '0, child_7_i = '0;
  logic [12:0] handle_i = '0;
  logic        full_limit_we_i = 1'b0;
  logic [12:0] full_limit_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [12:0] result_handle_o;
  logic [31:0] out_child_0_o, out_child_1_o, out_child_2_o, out_child_3_o;
  logic [31:0] out_child_4_o, out_child_5_o, out_child_6_o, out_child_7_o;
  logic [12:0] fill_level_o;

  // Shadow copy of the table used for prediction.
  logic [7:0]  shadow_tags[hcnt_pkg::SlotCount];
  logic [15:0] shadow_counts[hcnt_pkg::SlotCount];
  hcnt_pkg::node_t shadow_words[hcnt_pkg::SlotCount];
  int unsigned shadow_fill;
  logic [12:0] shadow_limit;

  outcome_t    pending_results[$];
  logic [12:0] live_handles[$];
  logic [12:0] last_handle;
  hcnt_pkg::node_t node_pool[PoolSize];
  int          errors = 0;
  int unsigned cycles = 0;
  bit          idling_on = 1'b1;

  hcnt_pkg::node_t got_words;
  assign got_words = {out_child_7_o, out_child_6_o, out_child_5_o, out_child_4_o,
                      out_child_3_o, out_child_2_o, out_child_1_o, out_child_0_o};

  hash_consed_node_table_unit uut (.*);

  always #6 clk_i = ~clk_i;

  // FNV-1a over the node bytes, word 0 first, low byte first.
  function automatic hcnt_pkg::word_t node_fnv(hcnt_pkg::node_t n);
    hcnt_pkg::word_t h;
    h = hcnt_pkg::FnvSeed;
    for (int i = 0; i < hcnt_pkg::WordsPerNode; i++)
      for (int b = 0; b < 4; b++)
        h = (h ^ {24'd0, n[i][8*b +: 8]}) * hcnt_pkg::FnvPrime;
    return h;
  endfunction

  // Applies one operation to the shadow table and returns the expected outcome.
  function automatic outcome_t table_apply(logic [1:0] k, hcnt_pkg::node_t n,
                                           logic [12:0] hd);
    outcome_t    r;
    hcnt_pkg::word_t h;
    int unsigned idx;
    logic [7:0]  tg;
    bit          found;
    r.status = hcnt_pkg::StBadHandle;
    r.hnd = '0;
    r.words = '0;
    case (k)
      hcnt_pkg::KindInsert: begin
        r.status = hcnt_pkg::StFull;
        if (shadow_fill <= shadow_limit) begin
          h = node_fnv(n);
          idx = h & (hcnt_pkg::SlotCount - 1) & ~32'd15;
          tg = h[hcnt_pkg::Log2Slots +: 8] | 8'd1;
          found = 1'b0;
          for (int p = 0; p < hcnt_pkg::SlotCount && !found; p++) begin
            if (shadow_tags[idx] == 0) begin
              shadow_tags[idx] = tg;
              shadow_words[idx] = n;
              shadow_counts[idx] = 16'd1;
              shadow_fill++;
              r.status = hcnt_pkg::StInserted;
              r.hnd = 13'(idx + 1);
              found = 1'b1;
            end else if (shadow_tags[idx] == tg && shadow_words[idx] == n) begin
              if (shadow_counts[idx] != 16'hFFFF) shadow_counts[idx]++;
              r.status = hcnt_pkg::StMatched;
              r.hnd = 13'(idx + 1);
              found = 1'b1;
            end else begin
              idx = (idx + 1) % hcnt_pkg::SlotCount;
            end
          end
        end
      end
      hcnt_pkg::KindRemove: begin
        if (hd != 0 && hd <= hcnt_pkg::SlotCount && shadow_tags[hd-1] != 0) begin
          if (shadow_counts[hd-1] != 0) shadow_counts[hd-1]--;
          if (shadow_counts[hd-1] == 0) begin
            shadow_tags[hd-1] = '0;
            if (shadow_fill != 0) shadow_fill--;
            r.status = hcnt_pkg::StFreed;
          end else begin
            r.status = hcnt_pkg::StDropped;
          end
        end
      end
      hcnt_pkg::KindRead: begin
        if (hd != 0 && hd <= hcnt_pkg::SlotCount) begin
          r.words = shadow_words[hd-1];
          r.status = hcnt_pkg::StReadDone;
        end
      end
      default: begin
        foreach (shadow_tags[i]) shadow_tags[i] = '0;
        shadow_fill = 0;
        r.status = hcnt_pkg::StCleared;
      end
    endcase
    r.fill = 13'(shadow_fill);
    return r;
  endfunction

  // Fixed node patterns for the directed part.
  function automatic hcnt_pkg::node_t pattern_node(int p);
    hcnt_pkg::node_t n;
    case (p)
      0: n = '0;
      1: n = '1;
      2: n = {8{32'h8080_80FF}};
      default:
        for (int i = 0; i < hcnt_pkg::WordsPerNode; i++) n[i] = 32'h0102_0304 * (i + 1);
    endcase
    return n;
  endfunction

  // Drives one transaction, waits for acceptance and records the prediction.
  task automatic issue(input logic [1:0] k, input hcnt_pkg::node_t n,
                       input logic [12:0] hd, output outcome_t r);
    if (idling_on && $urandom_range(0, 99) < 32) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    kind_i <= k;
    {child_7_i, child_6_i, child_5_i, child_4_i,
     child_3_i, child_2_i, child_1_i, child_0_i} <= n;
    handle_i <= hd;
    do @(posedge clk_i); while (busy_o);
    r = table_apply(k, n, hd);
    pending_results.push_back(r);
    if (r.status == hcnt_pkg::StInserted || r.status == hcnt_pkg::StMatched) begin
      last_handle = r.hnd;
      live_handles.push_back(r.hnd);
      if (live_handles.size() > 64) void'(live_handles.pop_front());
    end else if (k != hcnt_pkg::KindInsert) begin
      last_handle = hd;
    end
  endtask

  // Lets every result drain, then writes the fill limit.
  task automatic write_limit(input logic [12:0] v);
    start_i <= 1'b0;
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    full_limit_we_i <= 1'b1;
    full_limit_i <= v;
    @(posedge clk_i);
    full_limit_we_i <= 1'b0;
    shadow_limit = v;
  endtask

  function automatic logic [12:0] pick_known();
    if (live_handles.size() == 0) return 13'd0;
    return live_handles[$urandom_range(0, live_handles.size() - 1)];
  endfunction

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, status %0d", $time, status_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          errors++;
        end
        if (result_handle_o !== e.hnd) begin
          $display("%0t: handle expected %0d actual %0d", $time, e.hnd, result_handle_o);
          errors++;
        end
        for (int i = 0; i < hcnt_pkg::WordsPerNode; i++)
          if (got_words[i] !== e.words[i]) begin
            $display("%0t: word %0d expected %h actual %h", $time, i, e.words[i],
                     got_words[i]);
            errors++;
          end
        if (fill_level_o !== e.fill) begin
          $display("%0t: fill expected %0d actual %0d", $time, e.fill, fill_level_o);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_hash_consed_node_table_unit NOT OK");
      $finish;
    end
  end

  initial begin
    plan_row_t   plan[$];
    outcome_t    r;
    logic [12:0] limits[8];
    hcnt_pkg::node_t n;
    logic [12:0] hd;
    int          c;

    foreach (shadow_tags[i]) begin
      shadow_tags[i] = '0;
      shadow_counts[i] = '0;
      shadow_words[i] = '0;
    end
    shadow_fill = 0;
    shadow_limit = hcnt_pkg::FullLimitReset;
    last_handle = '0;
    foreach (node_pool[i])
      for (int w = 0; w < hcnt_pkg::WordsPerNode; w++) node_pool[i][w] = $urandom();
    limits = '{13'd4096, 13'd0, 13'd30, 13'd3840, 13'd12, 13'd4096, 13'd1, 13'd200};

    // Directed plan; typed rows carry the obvious status and fill level.
    plan = '{
      '{hcnt_pkg::KindInsert, 0, 0, 13'd0,    1, hcnt_pkg::StInserted,  13'd1},
      '{hcnt_pkg::KindInsert, 0, 0, 13'd0,    1, hcnt_pkg::StMatched,   13'd1},
      '{hcnt_pkg::KindInsert, 1, 0, 13'd0,    1, hcnt_pkg::StInserted,  13'd2},
      '{hcnt_pkg::KindInsert, 2, 0, 13'd0,    1, hcnt_pkg::StInserted,  13'd3},
      '{hcnt_pkg::KindRead,   0, 1, 13'd0,    1, hcnt_pkg::StReadDone,  13'd3},
      '{hcnt_pkg::KindRemove, 0, 1, 13'd0,    1, hcnt_pkg::StFreed,     13'd2},
      '{hcnt_pkg::KindRemove, 0, 1, 13'd0,    1, hcnt_pkg::StBadHandle, 13'd2},
      '{hcnt_pkg::KindRead,   0, 1, 13'd0,    1, hcnt_pkg::StReadDone,  13'd2},
      '{hcnt_pkg::KindRead,   0, 0, 13'd0,    1, hcnt_pkg::StBadHandle, 13'd2},
      '{hcnt_pkg::KindRead,   0, 0, 13'd4097, 1, hcnt_pkg::StBadHandle, 13'd2},
      '{hcnt_pkg::KindRead,   0, 0, 13'd8191, 1, hcnt_pkg::StBadHandle, 13'd2},
      '{hcnt_pkg::KindRemove, 0, 0, 13'd0,    1, hcnt_pkg::StBadHandle, 13'd2},
      '{hcnt_pkg::KindRemove, 0, 0, 13'd8191, 1, hcnt_pkg::StBadHandle, 13'd2},
      '{hcnt_pkg::KindInsert, 3, 0, 13'd0,    1, hcnt_pkg::StInserted,  13'd3},
      '{hcnt_pkg::KindInsert, 3, 0, 13'd0,    1, hcnt_pkg::StMatched,   13'd3},
      '{hcnt_pkg::KindRemove, 0, 1, 13'd0,    1, hcnt_pkg::StDropped,   13'd3},
      '{hcnt_pkg::KindRemove, 0, 1, 13'd0,    1, hcnt_pkg::StFreed,     13'd2},
      '{hcnt_pkg::KindInsert, 1, 0, 13'd0,    0, hcnt_pkg::StInserted,  13'd0},
      '{hcnt_pkg::KindClear,  0, 0, 13'd0,    1, hcnt_pkg::StCleared,   13'd0},
      '{hcnt_pkg::KindRemove, 0, 1, 13'd0,    1, hcnt_pkg::StBadHandle, 13'd0},
      '{hcnt_pkg::KindInsert, 0, 0, 13'd0,    1, hcnt_pkg::StInserted,  13'd1},
      '{hcnt_pkg::KindRead,   0, 1, 13'd0,    0, hcnt_pkg::StReadDone,  13'd0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    foreach (plan[i]) begin
      hd = plan[i].use_last ? last_handle : plan[i].hnd;
      issue(plan[i].kind, pattern_node(plan[i].pattern), hd, r);
      if (plan[i].typed && (r.status !== plan[i].status || r.fill !== plan[i].fill)) begin
        $display("%0t: row %0d expected status %0d fill %0d actual %0d %0d", $time, i,
                 plan[i].status, plan[i].fill, r.status, r.fill);
        errors++;
      end
    end

    // Random phases, each under its own fill limit; the third runs without gaps.
    foreach (limits[p]) begin
      write_limit(limits[p]);
      idling_on = (p != 2);
      for (int j = 0; j < 100; j++) begin
        c = $urandom_range(0, 999);
        if (c < 550) begin
          if ($urandom_range(0, 3) != 0) n = node_pool[$urandom_range(0, PoolSize - 1)];
          else for (int w = 0; w < hcnt_pkg::WordsPerNode; w++) n[w] = $urandom();
          issue(hcnt_pkg::KindInsert, n, 13'($urandom()), r);
        end else if (c < 750) begin
          hd = ($urandom_range(0, 4) != 0) ? pick_known() : 13'($urandom_range(0, 8191));
          issue(hcnt_pkg::KindRemove, hcnt_pkg::node_t'({$urandom(), $urandom()}), hd, r);
        end else if (c < 993) begin
          if ($urandom_range(0, 3) != 0) hd = pick_known();
          else hd = $urandom_range(0, 1) ? 13'd0 : 13'($urandom_range(4097, 8191));
          issue(hcnt_pkg::KindRead, '0, hd, r);
        end else begin
          issue(hcnt_pkg::KindClear, '0, 13'd0, r);
        end
      end
    end

    // Drain and let the block settle.
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_hash_consed_node_table_unit OK");
    end else begin
      $display("tb_hash_consed_node_table_unit NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/hcnt_pkg.sv
src/hcnt_ram.sv
src/hash_consed_node_table_unit.sv
src/hcnt_checker.sv
bench/tb_hash_consed_node_table_unit.sv
